>>> src/hufw_pkg.sv
// shared types and constants for the huffman table walk decoder
// used by hufw_ctrl, hufw_datapath and the top level; no dependencies
`default_nettype none

package hufw_pkg;

   localparam int WIN_W    = 32;
   localparam int WORD_W   = 16;
   localparam int ADDR_W   = 12;
   localparam int LEN_W    = 5;
   localparam int SYM_W    = 10;
   localparam int OFFS_W   = 15;
   localparam int LEAF_BIT = 15;

   localparam logic             FUNC_WRITE  = 1'b0;
   localparam logic             FUNC_DECODE = 1'b1;
   localparam logic [SYM_W-1:0] ESC_FIRST   = 10'h3FC;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_ESCAPE
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic write_table;
      logic start_walk;
      logic next_step;
      logic start_escape;
      logic finish_ok;
      logic finish_esc;
      logic finish_err;
   } hufw_cmd_type;

   // datapath to controller, all about the entry read last cycle
   typedef struct packed {
      logic is_leaf;
      logic is_escape;
      logic esc_ok;
      logic next_ok;
      logic last_level;
   } hufw_stat_type;

endpackage

`default_nettype wire

>>> src/hufw_ctrl.sv
// walk sequencer for the huffman table walk decoder
// depends on hufw_pkg for state, command and status types
`default_nettype none

module hufw_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic                   req_func,
   input  wire hufw_pkg::hufw_stat_type stat,
   output logic                        busy,
   output hufw_pkg::hufw_cmd_type      cmd
);
   import hufw_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_func == FUNC_DECODE) begin
                  cmd.start_walk = 1'b1;
                  state_in       = ST_WALK;
               end else begin
                  cmd.write_table = 1'b1;
               end
            end
         end
         ST_WALK: begin
            if (stat.is_leaf) begin
               if (!stat.is_escape) begin
                  cmd.finish_ok = 1'b1;
                  state_in      = ST_IDLE;
               end else if (stat.esc_ok) begin
                  cmd.start_escape = 1'b1;
                  state_in         = ST_ESCAPE;
               end else begin
                  cmd.finish_err = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else if (stat.last_level || !stat.next_ok) begin
               // ran out of levels or the pointer left the table
               cmd.finish_err = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.next_step = 1'b1;
            end
         end
         ST_ESCAPE: begin
            cmd.finish_esc = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> src/hufw_datapath.sv
// table memory, walk pointer, bit window and result registers
// depends on hufw_pkg; driven by hufw_ctrl commands
`default_nettype none

module hufw_datapath #(
   parameter int TABLE_DEPTH    = 4096,
   parameter int TWO_BIT_LEVELS = 8,
   parameter int ONE_BIT_LEVELS = 6
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire hufw_pkg::hufw_cmd_type            cmd,
   input  wire logic [hufw_pkg::ADDR_W-1:0]       req_table_address,
   input  wire logic [hufw_pkg::WORD_W-1:0]       req_table_word,
   input  wire logic [hufw_pkg::WIN_W-1:0]        req_bit_window,
   output hufw_pkg::hufw_stat_type                stat,
   output logic                                   rsp_valid,
   output logic [hufw_pkg::LEN_W-1:0]             rsp_code_length,
   output logic [hufw_pkg::WORD_W-1:0]            rsp_symbol,
   output logic [hufw_pkg::WIN_W-1:0]             rsp_remaining_bits,
   output logic                                   rsp_walk_error
);
   import hufw_pkg::*;

   localparam int AW     = $clog2(TABLE_DEPTH);
   // holds a table pointer plus the largest offset plus a step
   localparam int PTR_W  = $clog2(TABLE_DEPTH + 32772);
   localparam int LEVELS = TWO_BIT_LEVELS + ONE_BIT_LEVELS;
   localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int CMP_W  = LVL_W + 1;

   logic [WORD_W-1:0] table_mem [TABLE_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   logic [WIN_W-1:0]  window_ff;
   logic [WIN_W-1:0]  bits_ff;
   logic [AW-1:0]     ptr_ff;
   logic [LVL_W-1:0]  level_ff;
   logic [LEN_W-1:0]  len_ff;

   logic              rsp_valid_ff;
   logic [LEN_W-1:0]  rsp_len_ff;
   logic [WORD_W-1:0] rsp_sym_ff;
   logic [WIN_W-1:0]  rsp_rem_ff;
   logic              rsp_err_ff;

   logic [PTR_W-1:0]  wr_wide;
   logic              wr_ok;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     first_ptr;
   logic [SYM_W-1:0]  leaf_sym;
   logic [LEN_W-1:0]  leaf_len;
   logic [CMP_W-1:0]  next_level;
   logic              two_bit_next;
   logic [1:0]        step_bits;
   logic [PTR_W-1:0]  next_ptr;
   logic [PTR_W-1:0]  esc_ptr;
   logic [LEN_W-1:0]  shamt;
   logic              finish_any;

   assign wr_wide   = PTR_W'(req_table_address);
   assign wr_ok     = wr_wide < PTR_W'(TABLE_DEPTH);
   assign first_ptr = {{(AW-2){1'b0}}, req_bit_window[WIN_W-1:WIN_W-2]};

   assign leaf_sym  = rd_data_ff[SYM_W-1:0];
   assign leaf_len  = rd_data_ff[SYM_W+LEN_W-1:SYM_W];

   assign next_level   = CMP_W'(level_ff) + CMP_W'(1);
   assign two_bit_next = next_level < CMP_W'(TWO_BIT_LEVELS);
   assign step_bits    = two_bit_next ? bits_ff[WIN_W-1:WIN_W-2]
                                      : {1'b0, bits_ff[WIN_W-1]};
   assign next_ptr     = PTR_W'(ptr_ff) + PTR_W'(rd_data_ff[OFFS_W-1:0])
                       + PTR_W'(step_bits);
   // escape word sits one to four entries past the leaf
   assign esc_ptr      = PTR_W'(ptr_ff) + PTR_W'(leaf_sym[1:0]) + PTR_W'(1);

   assign stat.is_leaf    = rd_data_ff[LEAF_BIT];
   assign stat.is_escape  = leaf_sym >= ESC_FIRST;
   assign stat.esc_ok     = esc_ptr < PTR_W'(TABLE_DEPTH);
   assign stat.next_ok    = next_ptr < PTR_W'(TABLE_DEPTH);
   assign stat.last_level = level_ff == LVL_W'(LEVELS - 1);

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = first_ptr;
      if (cmd.start_walk) begin
         rd_en = 1'b1;
      end else if (cmd.next_step) begin
         rd_en   = 1'b1;
         rd_addr = next_ptr[AW-1:0];
      end else if (cmd.start_escape) begin
         rd_en   = 1'b1;
         rd_addr = esc_ptr[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_table && wr_ok) begin
         table_mem[wr_wide[AW-1:0]] <= req_table_word;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_walk) begin
         window_ff <= req_bit_window;
         bits_ff   <= req_bit_window << 2;
         ptr_ff    <= first_ptr;
         level_ff  <= '0;
      end else if (cmd.next_step) begin
         ptr_ff   <= next_ptr[AW-1:0];
         level_ff <= next_level[LVL_W-1:0];
         bits_ff  <= two_bit_next ? (bits_ff << 2) : (bits_ff << 1);
      end
      if (cmd.start_escape) begin
         len_ff <= leaf_len;
      end
   end

   assign shamt      = cmd.finish_esc ? len_ff : leaf_len;
   assign finish_any = cmd.finish_ok || cmd.finish_esc || cmd.finish_err;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= finish_any;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish_err) begin
         rsp_len_ff <= '0;
         rsp_sym_ff <= '0;
         rsp_rem_ff <= window_ff;
         rsp_err_ff <= 1'b1;
      end else if (cmd.finish_ok || cmd.finish_esc) begin
         rsp_len_ff <= shamt;
         rsp_sym_ff <= cmd.finish_esc ? rd_data_ff : WORD_W'(leaf_sym);
         rsp_rem_ff <= window_ff << shamt;
         rsp_err_ff <= 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_code_length    = rsp_len_ff;
   assign rsp_symbol         = rsp_sym_ff;
   assign rsp_remaining_bits = rsp_rem_ff;
   assign rsp_walk_error     = rsp_err_ff;

endmodule

`default_nettype wire

>>> src/huffman_table_walk_decoder.sv
// huffman table walk decoder, top level
// depends on hufw_pkg, hufw_ctrl and hufw_datapath
//
// channel  | handshake         | payload
// ---------+-------------------+-----------------------------------------------
// request  | start / busy      | req_func, req_table_address, req_table_word,
//          |                   | req_bit_window
// response | rsp_valid (pulse) | rsp_code_length, rsp_symbol,
//          |                   | rsp_remaining_bits, rsp_walk_error
//
// a table write keeps busy low, so writes can go every cycle
// a decode keeps busy high while it reads the table, one read per tree level
// visited (1 to TWO_BIT_LEVELS + ONE_BIT_LEVELS) plus one for an escape word;
// the chain of dependent reads on the single table read port sets its length
// rsp_valid pulses in the first cycle with busy low again; the next start may
// be taken in that same cycle, and the response side never stalls
// synchronous reset clears the sequencer; table contents are undefined until
// written
`default_nettype none

module huffman_table_walk_decoder #(
   parameter int TABLE_DEPTH    = 4096,
   parameter int TWO_BIT_LEVELS = 8,
   parameter int ONE_BIT_LEVELS = 6
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_func,
   input  wire logic [hufw_pkg::ADDR_W-1:0] req_table_address,
   input  wire logic [hufw_pkg::WORD_W-1:0] req_table_word,
   input  wire logic [hufw_pkg::WIN_W-1:0]  req_bit_window,
   output logic                             rsp_valid,
   output logic [hufw_pkg::LEN_W-1:0]       rsp_code_length,
   output logic [hufw_pkg::WORD_W-1:0]      rsp_symbol,
   output logic [hufw_pkg::WIN_W-1:0]       rsp_remaining_bits,
   output logic                             rsp_walk_error
);
   import hufw_pkg::*;

   hufw_cmd_type  cmd;
   hufw_stat_type stat;

   hufw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   hufw_datapath #(
      .TABLE_DEPTH    (TABLE_DEPTH),
      .TWO_BIT_LEVELS (TWO_BIT_LEVELS),
      .ONE_BIT_LEVELS (ONE_BIT_LEVELS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_table_address  (req_table_address),
      .req_table_word     (req_table_word),
      .req_bit_window     (req_bit_window),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_code_length    (rsp_code_length),
      .rsp_symbol         (rsp_symbol),
      .rsp_remaining_bits (rsp_remaining_bits),
      .rsp_walk_error     (rsp_walk_error)
   );

   // a response only appears once the walk has released the request side
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while a walk is still running");

   a_decode_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_func == FUNC_DECODE |=> busy)
      else $error("decode transfer did not start a walk");

   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_func == FUNC_WRITE |=> !busy && !rsp_valid)
      else $error("table write produced a response or went busy");

   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_walk_error |-> rsp_code_length == '0 && rsp_symbol == '0)
      else $error("error response carries a length or symbol");

endmodule

`default_nettype wire

>>> bench/huffman_table_walk_decoder_tb.sv
`timescale 1ns / 100ps
// testbench for huffman_table_walk_decoder: grows code trees on demand, checks every decode
// depends on hufw_pkg and huffman_table_walk_decoder

module huffman_table_walk_decoder_tb;
   import hufw_pkg::*;

   localparam int TABLE_DEPTH    = 4096;
   localparam int TWO_BIT_LEVELS = 8;
   localparam int ONE_BIT_LEVELS = 6;
   localparam int ITEM_TARGET    = 920;
   localparam int DRAIN_CYCLES   = 40;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [WIN_W-1:0]  window;
      logic [LEN_W-1:0]  code_length;
      logic [WORD_W-1:0] symbol;
      logic [WIN_W-1:0]  remaining_bits;
      logic              walk_error;
   } codeword_type;

   // shadow of the code table plus the codewords still owed by the block
   class decode_scoreboard;
      logic [WORD_W-1:0] tree_words[TABLE_DEPTH];
      bit                word_known[TABLE_DEPTH];
      codeword_type      awaited_codes[$];
      int                failures;

      function new();
         foreach (word_known[i]) word_known[i] = 1'b0;
         failures = 0;
      endfunction

      function void store_word(logic [ADDR_W-1:0] addr, logic [WORD_W-1:0] word);
         if (addr < TABLE_DEPTH) begin
            tree_words[addr] = word;
            word_known[addr] = 1'b1;
         end
      endfunction

      // missing returns the first never-written entry the walk would read, else -1
      function codeword_type walk_tree(logic [WIN_W-1:0] window, output int missing);
         codeword_type      cw;
         logic [WIN_W-1:0]  bits;
         logic [31:0]       ptr;
         logic [31:0]       esc_addr;
         logic [WORD_W-1:0] entry;
         logic [WORD_W-1:0] symbol_out;
         logic [SYM_W-1:0]  sym;
         bit                found;
         int                lvl;
         cw = '0;
         cw.window = window;
         cw.remaining_bits = window;
         cw.walk_error = 1'b1;
         bits = window;
         ptr = 0;
         entry = '0;
         found = 1'b0;
         missing = -1;
         for (lvl = 0; lvl < TWO_BIT_LEVELS + ONE_BIT_LEVELS; lvl++) begin
            if (lvl < TWO_BIT_LEVELS) ptr = ptr + bits[31:30];
            else ptr = ptr + bits[31];
            if (ptr >= TABLE_DEPTH) break;
            if (!word_known[ptr]) begin
               missing = ptr;
               return cw;
            end
            entry = tree_words[ptr];
            if (entry[LEAF_BIT]) begin
               found = 1'b1;
               break;
            end
            ptr = ptr + entry;
            bits = (lvl < TWO_BIT_LEVELS) ? bits << 2 : bits << 1;
         end
         if (found) begin
            sym = entry[SYM_W-1:0];
            symbol_out = WORD_W'(sym);
            if (sym >= ESC_FIRST) begin
               // escape: real symbol sits just past the leaf
               esc_addr = ptr + sym[1:0] + 1;
               if (esc_addr >= TABLE_DEPTH) found = 1'b0;
               else if (!word_known[esc_addr]) begin
                  missing = esc_addr;
                  return cw;
               end else symbol_out = tree_words[esc_addr];
            end
            if (found) begin
               cw.code_length = entry[LEAF_BIT-1 -: LEN_W];
               cw.symbol = symbol_out;
               cw.remaining_bits = window << cw.code_length;
               cw.walk_error = 1'b0;
            end
         end
         return cw;
      endfunction

      function void note_transfer(logic func, logic [ADDR_W-1:0] addr,
                                  logic [WORD_W-1:0] word, logic [WIN_W-1:0] window);
         int missing;
         if (func == FUNC_WRITE) store_word(addr, word);
         else awaited_codes.push_back(walk_tree(window, missing));
      endfunction

      function void check_result(logic [LEN_W-1:0] len, logic [WORD_W-1:0] sym,
                                 logic [WIN_W-1:0] rem, logic err);
         codeword_type want;
         if (awaited_codes.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected result: len %0d sym %h rem %h err %b",
                        len, sym, rem, err);
            return;
         end
         want = awaited_codes.pop_front();
         if (len !== want.code_length || sym !== want.symbol ||
             rem !== want.remaining_bits || err !== want.walk_error) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("mismatch window %h: exp len %0d sym %h rem %h err %b,",
                        want.window, want.code_length, want.symbol,
                        want.remaining_bits, want.walk_error,
                        " got len %0d sym %h rem %h err %b", len, sym, rem, err);
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_func;
   logic [ADDR_W-1:0]   req_table_address;
   logic [WORD_W-1:0]   req_table_word;
   logic [WIN_W-1:0]    req_bit_window;
   logic                rsp_valid;
   logic [LEN_W-1:0]    rsp_code_length;
   logic [WORD_W-1:0]   rsp_symbol;
   logic [WIN_W-1:0]    rsp_remaining_bits;
   logic                rsp_walk_error;

   decode_scoreboard sb;
   decode_scoreboard plan;
   int               items_sent = 0;
   int               quiet_left = 0;
   int               cycle_count = 0;

   huffman_table_walk_decoder #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .TWO_BIT_LEVELS(TWO_BIT_LEVELS),
      .ONE_BIT_LEVELS(ONE_BIT_LEVELS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_table_address (req_table_address),
      .req_table_word    (req_table_word),
      .req_bit_window    (req_bit_window),
      .rsp_valid         (rsp_valid),
      .rsp_code_length   (rsp_code_length),
      .rsp_symbol        (rsp_symbol),
      .rsp_remaining_bits(rsp_remaining_bits),
      .rsp_walk_error    (rsp_walk_error)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_code_length, rsp_symbol, rsp_remaining_bits, rsp_walk_error);
   end

   function automatic logic [WORD_W-1:0] leaf_word(logic [LEN_W-1:0] len,
                                                   logic [SYM_W-1:0] sym);
      return {1'b1, len, sym};
   endfunction

   function automatic logic [WORD_W-1:0] make_entry(int leaf_pct);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < leaf_pct) begin
         if ($urandom_range(0, 3) == 0)
            return leaf_word(LEN_W'($urandom), ESC_FIRST + SYM_W'($urandom_range(0, 3)));
         return leaf_word(LEN_W'($urandom), SYM_W'($urandom));
      end
      // inner node: mostly short hops, some far, a few off the end of the table
      pick = $urandom_range(0, 99);
      if (pick < 80) return WORD_W'($urandom_range(0, 60));
      if (pick < 95) return WORD_W'($urandom_range(0, 3000));
      return WORD_W'($urandom_range(0, 32767));
   endfunction

   task automatic send_item(logic func, logic [ADDR_W-1:0] addr, logic [WORD_W-1:0] word,
                            logic [WIN_W-1:0] window);
      int gap;
      int pick;
      if (func == FUNC_WRITE) plan.store_word(addr, word);
      gap = 0;
      if (quiet_left > 0) quiet_left--;
      else begin
         pick = $urandom_range(0, 99);
         if (pick < 4) quiet_left = $urandom_range(20, 60);
         else if (pick < 55) gap = 0;
         else if (pick < 90) gap = $urandom_range(1, 3);
         else gap = $urandom_range(8, 40);
      end
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start = 1'b1;
      req_func = func;
      req_table_address = addr;
      req_table_word = word;
      req_bit_window = window;
      do @(posedge clock); while (busy);
      sb.note_transfer(func, addr, word, window);
      items_sent++;
   endtask

   // writes every entry the walk would touch before it has been written, then decodes
   task automatic send_decode(logic [WIN_W-1:0] window, int leaf_pct);
      codeword_type cw;
      int           missing;
      cw = plan.walk_tree(window, missing);
      while (missing >= 0) begin
         send_item(FUNC_WRITE, ADDR_W'(missing), make_entry(leaf_pct), WIN_W'($urandom));
         cw = plan.walk_tree(window, missing);
      end
      send_item(FUNC_DECODE, ADDR_W'($urandom), WORD_W'($urandom), window);
   endtask

   initial begin
      int pick;
      int leaf_pct;
      logic [ADDR_W-1:0] addr;
      sb = new();
      plan = new();
      reset = 1'b1;
      start = 1'b0;
      req_func = FUNC_WRITE;
      req_table_address = '0;
      req_table_word = '0;
      req_bit_window = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // hand-built roots: max length leaf, escape leaf, hop to last entry, max offset
      send_item(FUNC_WRITE, 12'd0, leaf_word(5'd31, 10'h3FB), WIN_W'($urandom));
      send_item(FUNC_WRITE, 12'd1, leaf_word(5'd5, 10'h3FF), WIN_W'($urandom));
      send_item(FUNC_WRITE, 12'd5, 16'hFFFF, WIN_W'($urandom));
      send_item(FUNC_WRITE, 12'd2, 16'h0FFD, WIN_W'($urandom));
      send_item(FUNC_WRITE, 12'hFFF, leaf_word(5'd2, ESC_FIRST), WIN_W'($urandom));
      send_item(FUNC_WRITE, 12'd3, 16'h7FFF, WIN_W'($urandom));
      send_decode(32'h0000_0000, 0);
      send_decode(32'h3FFF_FFFF, 0);
      send_decode({2'b01, 30'($urandom)}, 0);
      send_decode(32'h8000_0000, 0);  // escape word past the table
      send_decode(32'hA000_0000, 0);  // node pointer past the table
      send_decode(32'hFFFF_FFFF, 0);
      // root loops onto itself: no leaf, or a leaf only in the one-bit levels
      send_item(FUNC_WRITE, 12'd0, 16'h0000, WIN_W'($urandom));
      send_decode(32'h0000_0000, 0);
      send_decode(32'h0000_8000, 0);
      send_item(FUNC_WRITE, 12'd0, leaf_word(5'd0, 10'h000), WIN_W'($urandom));
      send_decode({2'b00, 30'($urandom)}, 0);

      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            addr = ($urandom_range(0, 99) < 30) ? ADDR_W'($urandom_range(0, 15))
                                                : ADDR_W'($urandom);
            send_item(FUNC_WRITE, addr,
                      $urandom_range(0, 1) ? WORD_W'($urandom) : make_entry(35),
                      WIN_W'($urandom));
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  leaf_pct = 0;
               end
               1: begin
                  leaf_pct = 15;
               end
               2: begin
                  leaf_pct = 35;
               end
               default: begin
                  leaf_pct = 70;
               end
            endcase
            send_decode(WIN_W'($urandom), leaf_pct);
         end
      end

      @(negedge clock);
      start = 1'b0;
      while (sb.awaited_codes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
